[rtl/sxl_pkg.sv]
// Shared types, character codes and small helpers for the s-expression lexer.
// No dependencies; every other file in rtl/ refers to this package.
`default_nettype none

package sxl_pkg;

    // Defaults for the top-level parameters
    localparam int POS_BITS_DEF    = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int DEPTH_BITS_DEF  = 16;

    // Result queue depth, power of two, at least 4
    localparam int OQ_DEPTH = 4;

    // Fixed widths of the result fields
    localparam int KIND_W = 3;
    localparam int LINE_W = 16;
    localparam int OFF_W  = 32;
    localparam int LEN_W  = 16;
    localparam int ERR_W  = 3;
    localparam int FILE_W = 16;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STRING,
        MODE_SEMI,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BLOCK_STAR,
        MODE_DEAD
    } t_lex_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_WORD   = 3'd0,
        KIND_STRING = 3'd1,
        KIND_LEFT   = 3'd2,
        KIND_RIGHT  = 3'd3,
        KIND_ERROR  = 3'd4,
        KIND_DONE   = 3'd5
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE           = 3'd0,
        ERR_NULL_BYTE      = 3'd1,
        ERR_OPEN_STRING    = 3'd2,
        ERR_UNMATCHED_RIGHT = 3'd3,
        ERR_UNMATCHED_LEFT = 3'd4
    } t_err;

    typedef struct packed {
        t_kind             kind;
        logic [LINE_W-1:0] line;
        logic [LINE_W-1:0] column;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        t_err              err;
        logic              last;
    } t_result;

    // Up to two results per input beat, first one goes out first
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic is_break(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL ||
               c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI || c == CH_QUOTE;
    endfunction

    // Mode after a byte seen with no token in progress
    function automatic t_lex_mode idle_mode(input logic [7:0] c);
        t_lex_mode m;
        if (c == CH_NUL) begin
            m = MODE_DEAD;
        end else if (c == CH_SEMI) begin
            m = MODE_SEMI;
        end else if (c == CH_QUOTE) begin
            m = MODE_STRING;
        end else if (is_break(c)) begin
            m = MODE_IDLE;
        end else begin
            m = MODE_WORD;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/sxl_core.sv]
// Lexer state and per-byte token logic: one beat in, up to two results out.
// Depends on sxl_pkg.
`default_nettype none

module sxl_core #(
    parameter int POS_BITS    = sxl_pkg::POS_BITS_DEF,
    parameter int OFFSET_BITS = sxl_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = sxl_pkg::DEPTH_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_action,
    input  wire logic [7:0]    i_char_byte,
    output sxl_pkg::t_push     o_push
);

    localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

    sxl_pkg::t_lex_mode r_mode, n_mode;
    logic [POS_BITS-1:0]    r_line, n_line, r_col, n_col;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [POS_BITS-1:0]    r_tok_line, n_tok_line, r_tok_col, n_tok_col;
    logic [OFFSET_BITS-1:0] r_tok_off, n_tok_off;
    logic [sxl_pkg::LEN_W-1:0] r_tok_len, n_tok_len;
    logic [DEPTH_BITS-1:0]  r_depth, n_depth;
    logic [POS_BITS-1:0]    r_outer_line, n_outer_line, r_outer_col, n_outer_col;
    logic                   r_neg_seen, n_neg_seen;
    logic [POS_BITS-1:0]    r_neg_line, n_neg_line, r_neg_col, n_neg_col;

    // Effect of a byte taken with no token open
    logic [POS_BITS-1:0]    ib_line, ib_col, ib_tok_line, ib_tok_col;
    logic [OFFSET_BITS-1:0] ib_tok_off;
    logic [sxl_pkg::LEN_W-1:0] ib_tok_len;
    logic [DEPTH_BITS-1:0]  ib_depth;
    logic [POS_BITS-1:0]    ib_outer_line, ib_outer_col, ib_neg_line, ib_neg_col;
    logic                   ib_neg_seen;
    logic                   ib_emit;
    sxl_pkg::t_result       ib_res;

    sxl_pkg::t_result       status_res;
    sxl_pkg::t_result       word_res;

    function automatic logic [POS_BITS-1:0] bump(input logic [POS_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [sxl_pkg::LINE_W-1:0] pos_out(input logic [POS_BITS-1:0] v);
        logic [POS_BITS+sxl_pkg::LINE_W-1:0] w;
        w = {{sxl_pkg::LINE_W{1'b0}}, v};
        return w[sxl_pkg::LINE_W-1:0];
    endfunction

    function automatic logic [sxl_pkg::OFF_W-1:0] off_out(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+sxl_pkg::OFF_W-1:0] w;
        w = {{sxl_pkg::OFF_W{1'b0}}, v};
        return w[sxl_pkg::OFF_W-1:0];
    endfunction

    function automatic sxl_pkg::t_result mk_res(
        input sxl_pkg::t_kind             kind,
        input logic [POS_BITS-1:0]        ln,
        input logic [POS_BITS-1:0]        col,
        input logic [OFFSET_BITS-1:0]     off,
        input logic [sxl_pkg::LEN_W-1:0]  len,
        input sxl_pkg::t_err              err
    );
        sxl_pkg::t_result r;
        r.kind   = kind;
        r.line   = pos_out(ln);
        r.column = pos_out(col);
        r.offset = off_out(off);
        r.length = len;
        r.err    = err;
        r.last   = 1'b0;
        return r;
    endfunction

    // Next mode
    always_comb begin
        n_mode = r_mode;
        if (i_accept) begin
            if (i_action) begin
                n_mode = sxl_pkg::MODE_IDLE;
            end else begin
                unique case (r_mode)
                    sxl_pkg::MODE_DEAD: begin
                        n_mode = sxl_pkg::MODE_DEAD;
                    end
                    sxl_pkg::MODE_WORD: begin
                        if (i_char_byte == sxl_pkg::CH_NUL) begin
                            n_mode = sxl_pkg::MODE_DEAD;
                        end else if (sxl_pkg::is_break(i_char_byte)) begin
                            n_mode = sxl_pkg::idle_mode(i_char_byte);
                        end
                    end
                    sxl_pkg::MODE_STRING: begin
                        if (i_char_byte == sxl_pkg::CH_QUOTE) n_mode = sxl_pkg::MODE_IDLE;
                    end
                    sxl_pkg::MODE_SEMI: begin
                        // the byte after ';' already belongs to the comment
                        if (i_char_byte == sxl_pkg::CH_STAR) begin
                            n_mode = sxl_pkg::MODE_BLOCK;
                        end else if (i_char_byte == sxl_pkg::CH_NL) begin
                            n_mode = sxl_pkg::MODE_IDLE;
                        end else begin
                            n_mode = sxl_pkg::MODE_LINE;
                        end
                    end
                    sxl_pkg::MODE_LINE: begin
                        if (i_char_byte == sxl_pkg::CH_NL) n_mode = sxl_pkg::MODE_IDLE;
                    end
                    sxl_pkg::MODE_BLOCK: begin
                        if (i_char_byte == sxl_pkg::CH_STAR) n_mode = sxl_pkg::MODE_BLOCK_STAR;
                    end
                    sxl_pkg::MODE_BLOCK_STAR: begin
                        if (i_char_byte == sxl_pkg::CH_SEMI) begin
                            n_mode = sxl_pkg::MODE_IDLE;
                        end else if (i_char_byte != sxl_pkg::CH_STAR) begin
                            n_mode = sxl_pkg::MODE_BLOCK;
                        end
                    end
                    sxl_pkg::MODE_IDLE: begin
                        n_mode = sxl_pkg::idle_mode(i_char_byte);
                    end
                endcase
            end
        end
    end

    // Byte with no token open
    always_comb begin
        ib_line       = r_line;
        ib_col        = r_col;
        ib_tok_line   = r_tok_line;
        ib_tok_col    = r_tok_col;
        ib_tok_off    = r_tok_off;
        ib_tok_len    = r_tok_len;
        ib_depth      = r_depth;
        ib_outer_line = r_outer_line;
        ib_outer_col  = r_outer_col;
        ib_neg_seen   = r_neg_seen;
        ib_neg_line   = r_neg_line;
        ib_neg_col    = r_neg_col;
        ib_emit       = 1'b0;
        ib_res        = '0;
        if (i_char_byte == sxl_pkg::CH_NUL) begin
            ib_emit = 1'b1;
            ib_res  = mk_res(sxl_pkg::KIND_ERROR, r_line, r_col, r_off, '0,
                             sxl_pkg::ERR_NULL_BYTE);
        end else if (i_char_byte == sxl_pkg::CH_SPACE || i_char_byte == sxl_pkg::CH_TAB ||
                     i_char_byte == sxl_pkg::CH_CR) begin
            ib_col = bump(r_col);
        end else if (i_char_byte == sxl_pkg::CH_NL) begin
            ib_line = bump(r_line);
            ib_col  = POS_ONE;
        end else if (i_char_byte == sxl_pkg::CH_LPAREN) begin
            ib_emit = 1'b1;
            ib_res  = mk_res(sxl_pkg::KIND_LEFT, r_line, r_col, r_off, 16'd1,
                             sxl_pkg::ERR_NONE);
            if (!r_neg_seen && !(&r_depth)) begin
                ib_depth = r_depth + 1'b1;
                if (r_depth == '0) begin
                    ib_outer_line = r_line;
                    ib_outer_col  = r_col;
                end
            end
            ib_col = bump(r_col);
        end else if (i_char_byte == sxl_pkg::CH_RPAREN) begin
            ib_emit = 1'b1;
            ib_res  = mk_res(sxl_pkg::KIND_RIGHT, r_line, r_col, r_off, 16'd1,
                             sxl_pkg::ERR_NONE);
            if (!r_neg_seen) begin
                if (r_depth == '0) begin
                    ib_neg_seen = 1'b1;
                    ib_neg_line = r_line;
                    ib_neg_col  = r_col;
                end else begin
                    ib_depth = r_depth - 1'b1;
                end
            end
            ib_col = bump(r_col);
        end else if (i_char_byte == sxl_pkg::CH_SEMI) begin
            ib_col = bump(r_col);
        end else if (i_char_byte == sxl_pkg::CH_QUOTE) begin
            // string content starts after the quote
            ib_tok_line = r_line;
            ib_tok_col  = r_col;
            ib_tok_off  = r_off + 1'b1;
            ib_tok_len  = '0;
            ib_col      = bump(r_col);
        end else begin
            ib_tok_line = r_line;
            ib_tok_col  = r_col;
            ib_tok_off  = r_off;
            ib_tok_len  = 16'd1;
            ib_col      = bump(r_col);
        end
    end

    always_comb begin
        word_res = mk_res(sxl_pkg::KIND_WORD, r_tok_line, r_tok_col, r_tok_off, r_tok_len,
                          sxl_pkg::ERR_NONE);
        if (r_neg_seen) begin
            status_res = mk_res(sxl_pkg::KIND_ERROR, r_neg_line, r_neg_col, r_off, '0,
                                sxl_pkg::ERR_UNMATCHED_RIGHT);
        end else if (r_depth != '0) begin
            status_res = mk_res(sxl_pkg::KIND_ERROR, r_outer_line, r_outer_col, r_off, '0,
                                sxl_pkg::ERR_UNMATCHED_LEFT);
        end else begin
            status_res = mk_res(sxl_pkg::KIND_DONE, r_line, r_col, r_off, '0,
                                sxl_pkg::ERR_NONE);
        end
    end

    // Counters, token capture and results
    always_comb begin
        n_line       = r_line;
        n_col        = r_col;
        n_off        = r_off;
        n_tok_line   = r_tok_line;
        n_tok_col    = r_tok_col;
        n_tok_off    = r_tok_off;
        n_tok_len    = r_tok_len;
        n_depth      = r_depth;
        n_outer_line = r_outer_line;
        n_outer_col  = r_outer_col;
        n_neg_seen   = r_neg_seen;
        n_neg_line   = r_neg_line;
        n_neg_col    = r_neg_col;
        o_push       = '0;
        if (i_accept) begin
            if (i_action) begin
                if (r_mode == sxl_pkg::MODE_STRING) begin
                    o_push.count = 2'd1;
                    o_push.first = mk_res(sxl_pkg::KIND_ERROR, r_tok_line, r_tok_col,
                                          r_tok_off - 1'b1, '0, sxl_pkg::ERR_OPEN_STRING);
                end else if (r_mode == sxl_pkg::MODE_WORD) begin
                    o_push.count  = 2'd2;
                    o_push.first  = word_res;
                    o_push.second = status_res;
                end else if (r_mode != sxl_pkg::MODE_DEAD) begin
                    o_push.count = 2'd1;
                    o_push.first = status_res;
                end
                n_line       = POS_ONE;
                n_col        = POS_ONE;
                n_off        = '0;
                n_tok_line   = '0;
                n_tok_col    = '0;
                n_tok_off    = '0;
                n_tok_len    = '0;
                n_depth      = '0;
                n_outer_line = '0;
                n_outer_col  = '0;
                n_neg_seen   = 1'b0;
                n_neg_line   = '0;
                n_neg_col    = '0;
            end else begin
                if (r_mode != sxl_pkg::MODE_DEAD) n_off = r_off + 1'b1;
                unique case (r_mode)
                    sxl_pkg::MODE_DEAD: begin
                    end
                    sxl_pkg::MODE_IDLE, sxl_pkg::MODE_WORD: begin
                        if (r_mode == sxl_pkg::MODE_WORD &&
                            i_char_byte != sxl_pkg::CH_NUL &&
                            !sxl_pkg::is_break(i_char_byte)) begin
                            if (!(&r_tok_len)) n_tok_len = r_tok_len + 1'b1;
                            n_col = bump(r_col);
                        end else if (r_mode == sxl_pkg::MODE_WORD &&
                                     i_char_byte == sxl_pkg::CH_NUL) begin
                            // word in progress is dropped
                            o_push.count = 2'd1;
                            o_push.first = ib_res;
                        end else begin
                            n_line       = ib_line;
                            n_col        = ib_col;
                            n_tok_line   = ib_tok_line;
                            n_tok_col    = ib_tok_col;
                            n_tok_off    = ib_tok_off;
                            n_tok_len    = ib_tok_len;
                            n_depth      = ib_depth;
                            n_outer_line = ib_outer_line;
                            n_outer_col  = ib_outer_col;
                            n_neg_seen   = ib_neg_seen;
                            n_neg_line   = ib_neg_line;
                            n_neg_col    = ib_neg_col;
                            if (r_mode == sxl_pkg::MODE_WORD) begin
                                o_push.first  = word_res;
                                o_push.second = ib_res;
                                o_push.count  = ib_emit ? 2'd2 : 2'd1;
                            end else begin
                                o_push.first = ib_res;
                                o_push.count = {1'b0, ib_emit};
                            end
                        end
                    end
                    sxl_pkg::MODE_STRING: begin
                        if (i_char_byte == sxl_pkg::CH_QUOTE) begin
                            n_col        = bump(r_col);
                            o_push.count = 2'd1;
                            o_push.first = mk_res(sxl_pkg::KIND_STRING, r_tok_line,
                                                  r_tok_col, r_tok_off, r_tok_len,
                                                  sxl_pkg::ERR_NONE);
                        end else begin
                            if (i_char_byte == sxl_pkg::CH_NL) begin
                                n_line = bump(r_line);
                                n_col  = POS_ONE;
                            end else begin
                                n_col = bump(r_col);
                            end
                            if (!(&r_tok_len)) n_tok_len = r_tok_len + 1'b1;
                        end
                    end
                    sxl_pkg::MODE_SEMI, sxl_pkg::MODE_LINE, sxl_pkg::MODE_BLOCK,
                    sxl_pkg::MODE_BLOCK_STAR: begin
                        // inside comments only line, column and offset move
                        if (i_char_byte == sxl_pkg::CH_NL) begin
                            n_line = bump(r_line);
                            n_col  = POS_ONE;
                        end else begin
                            n_col = bump(r_col);
                        end
                    end
                endcase
            end
            if (o_push.count == 2'd2) begin
                o_push.second.last = 1'b1;
            end else begin
                o_push.first.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sxl_pkg::MODE_IDLE;
            r_line       <= POS_ONE;
            r_col        <= POS_ONE;
            r_off        <= '0;
            r_tok_line   <= '0;
            r_tok_col    <= '0;
            r_tok_off    <= '0;
            r_tok_len    <= '0;
            r_depth      <= '0;
            r_outer_line <= '0;
            r_outer_col  <= '0;
            r_neg_seen   <= 1'b0;
            r_neg_line   <= '0;
            r_neg_col    <= '0;
        end else begin
            r_mode       <= n_mode;
            r_line       <= n_line;
            r_col        <= n_col;
            r_off        <= n_off;
            r_tok_line   <= n_tok_line;
            r_tok_col    <= n_tok_col;
            r_tok_off    <= n_tok_off;
            r_tok_len    <= n_tok_len;
            r_depth      <= n_depth;
            r_outer_line <= n_outer_line;
            r_outer_col  <= n_outer_col;
            r_neg_seen   <= n_neg_seen;
            r_neg_line   <= n_neg_line;
            r_neg_col    <= n_neg_col;
        end
    end

endmodule

`default_nettype wire

[rtl/sxl_outq.sv]
// Result queue: takes up to two results a cycle, hands out one per beat.
// Depends on sxl_pkg.
`default_nettype none

module sxl_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sxl_pkg::t_push    i_push,
    input  wire logic              i_pop,
    output sxl_pkg::t_result       o_head,
    output logic                   o_valid,
    output logic                   o_room
);

    localparam int PTR_W = $clog2(sxl_pkg::OQ_DEPTH);
    localparam int CNT_W = $clog2(sxl_pkg::OQ_DEPTH + 1);

    sxl_pkg::t_result r_entry [sxl_pkg::OQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] wr_ptr_1;

    assign o_valid  = r_count != '0;
    // room for a beat that yields two results
    assign o_room   = r_count <= CNT_W'(sxl_pkg::OQ_DEPTH - 2);
    assign o_head   = r_entry[r_rd_ptr];
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.count);
        n_rd_ptr = (i_pop && o_valid) ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + {{(CNT_W-2){1'b0}}, i_push.count}
                   - {{(CNT_W-1){1'b0}}, (i_pop && o_valid)};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_entry[r_wr_ptr] <= i_push.first;
        if (i_push.count == 2'd2) r_entry[wr_ptr_1] <= i_push.second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[rtl/sexpr_script_lexer.sv]
// Top level of the s-expression lexer: file number register, lexer core, result queue.
// Depends on sxl_pkg, sxl_core and sxl_outq.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  input   | in        | i_valid / o_stall  | i_action, i_char_byte
//  result  | out       | o_valid / i_stall  | o_token_kind .. o_last_of_run
//  config  | in        | i_cfg_wr_en        | i_cfg_wr_data (file number)
//
// One byte or end beat is taken per cycle while o_stall is low; its results enter a
// four-entry queue in the same edge and leave one per output beat from the next cycle on.
// o_stall rises while fewer than two queue slots are free, so a beat that yields two
// results (word plus delimiter token or status) costs two output beats.
// Synchronous active-low reset returns all lexer state to the start of a script and
// empties the queue; there is no clearing pass.
`default_nettype none

module sexpr_script_lexer #(
    parameter int POS_BITS    = sxl_pkg::POS_BITS_DEF,
    parameter int OFFSET_BITS = sxl_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = sxl_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [sxl_pkg::FILE_W-1:0]   i_cfg_wr_data,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_action,
    input  wire logic [7:0]                   i_char_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [sxl_pkg::KIND_W-1:0]        o_token_kind,
    output logic [sxl_pkg::LINE_W-1:0]        o_start_line,
    output logic [sxl_pkg::LINE_W-1:0]        o_start_column,
    output logic [sxl_pkg::OFF_W-1:0]         o_start_offset,
    output logic [sxl_pkg::LEN_W-1:0]         o_token_length,
    output logic [sxl_pkg::ERR_W-1:0]         o_error_code,
    output logic [sxl_pkg::FILE_W-1:0]        o_source_file,
    output logic                              o_last_of_run
);

    logic [sxl_pkg::FILE_W-1:0] r_file_number;
    logic                       room;
    logic                       accept;
    sxl_pkg::t_push             push;
    sxl_pkg::t_result           head;

    assign o_stall = !room;
    assign accept  = i_valid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_number <= '0;
        end else if (i_cfg_wr_en) begin
            r_file_number <= i_cfg_wr_data;
        end
    end

    sxl_core #(
        .POS_BITS    (POS_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_char_byte (i_char_byte),
        .o_push      (push)
    );

    sxl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_head  (head),
        .o_valid (o_valid),
        .o_room  (room)
    );

    // user writes file number only while idle (unchecked); live value is the emit-time one
    assign o_token_kind   = head.kind;
    assign o_start_line   = head.line;
    assign o_start_column = head.column;
    assign o_start_offset = head.offset;
    assign o_token_length = head.length;
    assign o_error_code   = head.err;
    assign o_source_file  = r_file_number;
    assign o_last_of_run  = head.last;

endmodule

`default_nettype wire

[rtl/sxl_checker.sv]
// Port-level checks on the lexer result channel, bound to sexpr_script_lexer.
// Depends on sxl_pkg.
`default_nettype none

module sxl_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic [sxl_pkg::KIND_W-1:0]   o_token_kind,
    input wire logic [sxl_pkg::LEN_W-1:0]    o_token_length,
    input wire logic [sxl_pkg::ERR_W-1:0]    o_error_code,
    input wire logic                         o_last_of_run
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result valid dropped while stalled");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_token_kind == sxl_pkg::KIND_ERROR) == (o_error_code != '0)))
        else $error("error code does not match token kind");

    a_paren_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == sxl_pkg::KIND_LEFT ||
                    o_token_kind == sxl_pkg::KIND_RIGHT) |-> o_token_length == 16'd1)
        else $error("paren token length is not one");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == sxl_pkg::KIND_DONE ||
                    o_token_kind == sxl_pkg::KIND_ERROR) |-> o_last_of_run)
        else $error("status result not marked last");

endmodule

bind sexpr_script_lexer sxl_checker u_sxl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_token_kind   (o_token_kind),
    .o_token_length (o_token_length),
    .o_error_code   (o_error_code),
    .o_last_of_run  (o_last_of_run)
);

`default_nettype wire

[test/tb_sexpr_script_lexer.sv]
// Self-checking testbench for sexpr_script_lexer: a table of directed beats, then random
// scripts under three sender/receiver idling mixes.
// Depends on sxl_pkg and the lexer RTL only.
module tb_sexpr_script_lexer;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 2_000_000;

    typedef struct packed {
        sxl_pkg::t_kind                     kind;
        logic [sxl_pkg::LINE_W-1:0]         line;
        logic [sxl_pkg::LINE_W-1:0]         column;
        logic [sxl_pkg::OFF_W-1:0]          offset;
        logic [sxl_pkg::LEN_W-1:0]          length;
        sxl_pkg::t_err                      err;
        logic [sxl_pkg::FILE_W-1:0]         file;
        logic                               last;
    } t_lex_token;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
        logic       has_want;
        t_lex_token want;
    } t_script_row;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [sxl_pkg::FILE_W-1:0]  cfg_wr_data = '0;
    logic                        byte_valid = 1'b0;
    logic                        byte_stall;
    logic                        byte_action = 1'b0;
    logic [7:0]                  byte_char = 8'h00;
    logic                        token_valid;
    logic                        token_stall = 1'b0;
    logic [sxl_pkg::KIND_W-1:0]  token_kind;
    logic [sxl_pkg::LINE_W-1:0]  token_line;
    logic [sxl_pkg::LINE_W-1:0]  token_column;
    logic [sxl_pkg::OFF_W-1:0]   token_offset;
    logic [sxl_pkg::LEN_W-1:0]   token_length;
    logic [sxl_pkg::ERR_W-1:0]   token_err;
    logic [sxl_pkg::FILE_W-1:0]  token_file;
    logic                        token_last;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int tokens_seen    = 0;
    int live_beats     = 0;
    int cycle_count    = 0;

    t_lex_token  tokens_due[$];
    t_lex_token  beat_tokens[$];
    t_script_row script_rows[29];

    // Predictor state
    sxl_pkg::t_lex_mode lx_mode;
    logic [15:0] lx_line, lx_col, lx_tok_line, lx_tok_col, lx_tok_len;
    logic [31:0] lx_off, lx_tok_off;
    logic [15:0] lx_depth, lx_open_line, lx_open_col, lx_neg_line, lx_neg_col;
    logic        lx_neg_seen;
    logic [15:0] lx_file;

    sexpr_script_lexer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_valid        (byte_valid),
        .o_stall        (byte_stall),
        .i_action       (byte_action),
        .i_char_byte    (byte_char),
        .o_valid        (token_valid),
        .i_stall        (token_stall),
        .o_token_kind   (token_kind),
        .o_start_line   (token_line),
        .o_start_column (token_column),
        .o_start_offset (token_offset),
        .o_token_length (token_length),
        .o_error_code   (token_err),
        .o_source_file  (token_file),
        .o_last_of_run  (token_last)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [15:0] sat_up(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c == sxl_pkg::CH_SPACE || c == sxl_pkg::CH_TAB || c == sxl_pkg::CH_CR ||
               c == sxl_pkg::CH_NL || c == sxl_pkg::CH_LPAREN || c == sxl_pkg::CH_RPAREN ||
               c == sxl_pkg::CH_SEMI || c == sxl_pkg::CH_QUOTE;
    endfunction

    task automatic lex_restart();
        lx_mode      = sxl_pkg::MODE_IDLE;
        lx_line      = 16'd1;
        lx_col       = 16'd1;
        lx_off       = '0;
        lx_tok_line  = '0;
        lx_tok_col   = '0;
        lx_tok_off   = '0;
        lx_tok_len   = '0;
        lx_depth     = '0;
        lx_open_line = '0;
        lx_open_col  = '0;
        lx_neg_seen  = 1'b0;
        lx_neg_line  = '0;
        lx_neg_col   = '0;
    endtask

    task automatic add_token(input sxl_pkg::t_kind k, input logic [15:0] ln,
                             input logic [15:0] col, input logic [31:0] off,
                             input logic [15:0] len, input sxl_pkg::t_err e);
        t_lex_token t;
        t.kind   = k;
        t.line   = ln;
        t.column = col;
        t.offset = off;
        t.length = len;
        t.err    = e;
        t.file   = lx_file;
        t.last   = 1'b0;
        beat_tokens.push_back(t);
    endtask

    // Byte seen between tokens
    task automatic lex_between(input logic [7:0] c);
        if (c == sxl_pkg::CH_NUL) begin
            add_token(sxl_pkg::KIND_ERROR, lx_line, lx_col, lx_off, 16'd0,
                      sxl_pkg::ERR_NULL_BYTE);
            lx_mode = sxl_pkg::MODE_DEAD;
        end else if (c == sxl_pkg::CH_SPACE || c == sxl_pkg::CH_TAB ||
                     c == sxl_pkg::CH_CR) begin
            lx_col = sat_up(lx_col);
        end else if (c == sxl_pkg::CH_NL) begin
            lx_line = sat_up(lx_line);
            lx_col  = 16'd1;
        end else if (c == sxl_pkg::CH_LPAREN) begin
            add_token(sxl_pkg::KIND_LEFT, lx_line, lx_col, lx_off, 16'd1, sxl_pkg::ERR_NONE);
            if (!lx_neg_seen && lx_depth != 16'hFFFF) begin
                lx_depth = lx_depth + 16'd1;
                if (lx_depth == 16'd1) begin
                    lx_open_line = lx_line;
                    lx_open_col  = lx_col;
                end
            end
            lx_col = sat_up(lx_col);
        end else if (c == sxl_pkg::CH_RPAREN) begin
            add_token(sxl_pkg::KIND_RIGHT, lx_line, lx_col, lx_off, 16'd1, sxl_pkg::ERR_NONE);
            if (!lx_neg_seen) begin
                if (lx_depth == 16'd0) begin
                    lx_neg_seen = 1'b1;
                    lx_neg_line = lx_line;
                    lx_neg_col  = lx_col;
                end else begin
                    lx_depth = lx_depth - 16'd1;
                end
            end
            lx_col = sat_up(lx_col);
        end else if (c == sxl_pkg::CH_SEMI) begin
            lx_col  = sat_up(lx_col);
            lx_mode = sxl_pkg::MODE_SEMI;
        end else if (c == sxl_pkg::CH_QUOTE) begin
            lx_tok_line = lx_line;
            lx_tok_col  = lx_col;
            lx_tok_off  = lx_off + 32'd1;
            lx_tok_len  = 16'd0;
            lx_col      = sat_up(lx_col);
            lx_mode     = sxl_pkg::MODE_STRING;
        end else begin
            lx_tok_line = lx_line;
            lx_tok_col  = lx_col;
            lx_tok_off  = lx_off;
            lx_tok_len  = 16'd1;
            lx_col      = sat_up(lx_col);
            lx_mode     = sxl_pkg::MODE_WORD;
        end
    endtask

    task automatic lex_comment(input logic [7:0] c, input sxl_pkg::t_lex_mode stay);
        if (c == sxl_pkg::CH_NL) begin
            lx_line = sat_up(lx_line);
            lx_col  = 16'd1;
            lx_mode = (stay == sxl_pkg::MODE_LINE) ? sxl_pkg::MODE_IDLE : sxl_pkg::MODE_BLOCK;
        end else begin
            lx_col  = sat_up(lx_col);
            lx_mode = stay;
        end
    endtask

    // Tokens caused by one accepted beat land in beat_tokens
    task automatic scan_beat(input logic act, input logic [7:0] c);
        beat_tokens.delete();
        if (act) begin
            if (lx_mode == sxl_pkg::MODE_STRING) begin
                add_token(sxl_pkg::KIND_ERROR, lx_tok_line, lx_tok_col, lx_tok_off - 32'd1,
                          16'd0, sxl_pkg::ERR_OPEN_STRING);
            end else if (lx_mode != sxl_pkg::MODE_DEAD) begin
                if (lx_mode == sxl_pkg::MODE_WORD)
                    add_token(sxl_pkg::KIND_WORD, lx_tok_line, lx_tok_col, lx_tok_off,
                              lx_tok_len, sxl_pkg::ERR_NONE);
                if (lx_neg_seen)
                    add_token(sxl_pkg::KIND_ERROR, lx_neg_line, lx_neg_col, lx_off, 16'd0,
                              sxl_pkg::ERR_UNMATCHED_RIGHT);
                else if (lx_depth != 16'd0)
                    add_token(sxl_pkg::KIND_ERROR, lx_open_line, lx_open_col, lx_off, 16'd0,
                              sxl_pkg::ERR_UNMATCHED_LEFT);
                else
                    add_token(sxl_pkg::KIND_DONE, lx_line, lx_col, lx_off, 16'd0,
                              sxl_pkg::ERR_NONE);
            end
            lex_restart();
        end else if (lx_mode != sxl_pkg::MODE_DEAD) begin
            case (lx_mode)
                sxl_pkg::MODE_WORD: begin
                    if (c == sxl_pkg::CH_NUL) begin
                        add_token(sxl_pkg::KIND_ERROR, lx_line, lx_col, lx_off, 16'd0,
                                  sxl_pkg::ERR_NULL_BYTE);
                        lx_mode = sxl_pkg::MODE_DEAD;
                    end else if (is_delim(c)) begin
                        add_token(sxl_pkg::KIND_WORD, lx_tok_line, lx_tok_col, lx_tok_off,
                                  lx_tok_len, sxl_pkg::ERR_NONE);
                        lx_mode = sxl_pkg::MODE_IDLE;
                        lex_between(c);
                    end else begin
                        lx_tok_len = sat_up(lx_tok_len);
                        lx_col     = sat_up(lx_col);
                    end
                end
                sxl_pkg::MODE_STRING: begin
                    if (c == sxl_pkg::CH_QUOTE) begin
                        lx_col = sat_up(lx_col);
                        add_token(sxl_pkg::KIND_STRING, lx_tok_line, lx_tok_col, lx_tok_off,
                                  lx_tok_len, sxl_pkg::ERR_NONE);
                        lx_mode = sxl_pkg::MODE_IDLE;
                    end else begin
                        if (c == sxl_pkg::CH_NL) begin
                            lx_line = sat_up(lx_line);
                            lx_col  = 16'd1;
                        end else begin
                            lx_col = sat_up(lx_col);
                        end
                        lx_tok_len = sat_up(lx_tok_len);
                    end
                end
                sxl_pkg::MODE_SEMI: begin
                    if (c == sxl_pkg::CH_STAR) begin
                        lx_col  = sat_up(lx_col);
                        lx_mode = sxl_pkg::MODE_BLOCK;
                    end else begin
                        lex_comment(c, sxl_pkg::MODE_LINE);
                    end
                end
                sxl_pkg::MODE_LINE: lex_comment(c, sxl_pkg::MODE_LINE);
                sxl_pkg::MODE_BLOCK: begin
                    if (c == sxl_pkg::CH_STAR) begin
                        lx_col  = sat_up(lx_col);
                        lx_mode = sxl_pkg::MODE_BLOCK_STAR;
                    end else begin
                        lex_comment(c, sxl_pkg::MODE_BLOCK);
                    end
                end
                sxl_pkg::MODE_BLOCK_STAR: begin
                    if (c == sxl_pkg::CH_SEMI) begin
                        lx_col  = sat_up(lx_col);
                        lx_mode = sxl_pkg::MODE_IDLE;
                    end else if (c == sxl_pkg::CH_STAR) begin
                        lx_col = sat_up(lx_col);
                    end else begin
                        lex_comment(c, sxl_pkg::MODE_BLOCK);
                    end
                end
                default: lex_between(c);
            endcase
            lx_off = lx_off + 32'd1;
        end
        if (beat_tokens.size() != 0)
            beat_tokens[beat_tokens.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------- driving

    task automatic send_beat(input logic act, input logic [7:0] c, input logic has_want,
                             input t_lex_token want);
        if ($urandom_range(99) < send_gap_pct) begin
            byte_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        byte_valid  <= 1'b1;
        byte_action <= act;
        byte_char   <= c;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        // beat taken at this edge
        if (lx_mode != sxl_pkg::MODE_DEAD)
            live_beats++;
        scan_beat(act, c);
        if (has_want) begin
            want.file = lx_file;
            want.last = 1'b1;
            tokens_due.push_back(want);
        end else begin
            foreach (beat_tokens[k])
                tokens_due.push_back(beat_tokens[k]);
        end
    endtask

    task automatic feed(input logic [7:0] c);
        send_beat(1'b0, c, 1'b0, '0);
    endtask

    task automatic finish_script();
        send_beat(1'b1, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    // Wait until every token is out and the block has gone quiet
    task automatic settle();
        byte_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_file(input logic [15:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        lx_file = v;
    endtask

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (is_delim(c));
        return c;
    endfunction

    function automatic logic [7:0] text_byte(input logic [7:0] stop_a, input logic [7:0] stop_b);
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == stop_a || c == stop_b);
        return c;
    endfunction

    function automatic t_script_row plain_row(input logic act, input logic [7:0] c);
        t_script_row r;
        r        = '0;
        r.action = act;
        r.ch     = c;
        return r;
    endfunction

    function automatic t_script_row fixed_row(input logic act, input logic [7:0] c,
            input sxl_pkg::t_kind k, input logic [15:0] ln, input logic [15:0] col,
            input logic [31:0] off, input logic [15:0] len, input sxl_pkg::t_err e);
        t_script_row r;
        r             = plain_row(act, c);
        r.has_want    = 1'b1;
        r.want.kind   = k;
        r.want.line   = ln;
        r.want.column = col;
        r.want.offset = off;
        r.want.length = len;
        r.want.err    = e;
        return r;
    endfunction

    // Mostly well-formed scripts with random content, some noise and loose ends
    task automatic random_script();
        int         pieces;
        int         depth;
        int         n;
        logic [7:0] c;
        pieces = $urandom_range(12);
        depth  = 0;
        repeat (pieces) begin
            case ($urandom_range(14))
                0, 1, 2: begin
                    n = $urandom_range(1, 6);
                    repeat (n) feed(word_byte());
                end
                3, 4: begin
                    feed(sxl_pkg::CH_QUOTE);
                    n = $urandom_range(6);
                    repeat (n) feed(text_byte(sxl_pkg::CH_QUOTE, sxl_pkg::CH_QUOTE));
                    feed(sxl_pkg::CH_QUOTE);
                end
                5, 6: begin
                    feed(sxl_pkg::CH_LPAREN);
                    depth++;
                end
                7, 8: begin
                    if (depth > 0 || $urandom_range(9) == 0) begin
                        feed(sxl_pkg::CH_RPAREN);
                        depth--;
                    end
                end
                9, 10: begin
                    case ($urandom_range(3))
                        0: c = sxl_pkg::CH_SPACE;
                        1: c = sxl_pkg::CH_TAB;
                        2: c = sxl_pkg::CH_CR;
                        default: c = sxl_pkg::CH_NL;
                    endcase
                    feed(c);
                end
                11: begin
                    feed(sxl_pkg::CH_SEMI);
                    n = $urandom_range(5);
                    repeat (n) feed(text_byte(sxl_pkg::CH_NL, sxl_pkg::CH_STAR));
                    feed(sxl_pkg::CH_NL);
                end
                12: begin
                    feed(sxl_pkg::CH_SEMI);
                    feed(sxl_pkg::CH_STAR);
                    n = $urandom_range(6);
                    repeat (n) begin
                        case ($urandom_range(4))
                            0: c = sxl_pkg::CH_STAR;
                            1: c = sxl_pkg::CH_SEMI;
                            2: c = sxl_pkg::CH_NL;
                            default: c = 8'($urandom_range(255));
                        endcase
                        feed(c);
                    end
                    // sometimes left open to the end of the script
                    if ($urandom_range(3) != 0) begin
                        feed(sxl_pkg::CH_STAR);
                        feed(sxl_pkg::CH_SEMI);
                    end
                end
                13: feed(8'($urandom_range(255)));
                default: feed(($urandom_range(5) == 0) ? sxl_pkg::CH_NUL : word_byte());
            endcase
        end
        if ($urandom_range(4) != 0) begin
            while (depth > 0) begin
                feed(sxl_pkg::CH_RPAREN);
                depth--;
            end
        end
        if ($urandom_range(9) == 0) begin
            feed(sxl_pkg::CH_QUOTE);
            n = $urandom_range(4);
            repeat (n) feed(text_byte(sxl_pkg::CH_QUOTE, sxl_pkg::CH_QUOTE));
        end
        finish_script();
    endtask

    task automatic random_phase(input int beats);
        int stop_at;
        stop_at = live_beats + beats;
        while (live_beats < stop_at) random_script();
    endtask

    // ---------------------------------------------------------------- checking

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("%0t: token %0d %s: got %0h, want %0h", $time, tokens_seen, what,
                 got, want);
    endtask

    always @(posedge clk) begin
        token_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin : token_check
        t_lex_token want;
        if (rst_n && token_valid && !token_stall) begin
            tokens_seen++;
            if (tokens_due.size() == 0) begin
                note_mismatch("unexpected, kind", 32'(token_kind), 32'hFFFF_FFFF);
            end else begin
                want = tokens_due.pop_front();
                if (token_kind != want.kind)
                    note_mismatch("kind", 32'(token_kind), 32'(want.kind));
                if (token_line != want.line)
                    note_mismatch("line", 32'(token_line), 32'(want.line));
                if (token_column != want.column)
                    note_mismatch("column", 32'(token_column), 32'(want.column));
                if (token_offset != want.offset)
                    note_mismatch("offset", token_offset, want.offset);
                if (token_length != want.length)
                    note_mismatch("length", 32'(token_length), 32'(want.length));
                if (token_err != want.err)
                    note_mismatch("error code", 32'(token_err), 32'(want.err));
                if (token_file != want.file)
                    note_mismatch("file", 32'(token_file), 32'(want.file));
                if (token_last != want.last)
                    note_mismatch("last", 32'(token_last), 32'(want.last));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[sexpr_script_lexer] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        lex_restart();
        lx_file = '0;
        script_rows = '{
            fixed_row(1'b1, 8'hFF, sxl_pkg::KIND_DONE, 16'd1, 16'd1, 32'd0, 16'd0,
                      sxl_pkg::ERR_NONE),
            fixed_row(1'b0, sxl_pkg::CH_NUL, sxl_pkg::KIND_ERROR, 16'd1, 16'd1, 32'd0,
                      16'd0, sxl_pkg::ERR_NULL_BYTE),
            plain_row(1'b0, sxl_pkg::CH_LPAREN),     // ignored after an error
            plain_row(1'b1, 8'h00),                  // silent restart
            fixed_row(1'b0, sxl_pkg::CH_RPAREN, sxl_pkg::KIND_RIGHT, 16'd1, 16'd1, 32'd0,
                      16'd1, sxl_pkg::ERR_NONE),
            plain_row(1'b0, 8'h61),
            plain_row(1'b0, 8'hFF),
            plain_row(1'b0, sxl_pkg::CH_LPAREN),     // word, then the paren
            plain_row(1'b0, sxl_pkg::CH_SEMI),
            plain_row(1'b0, sxl_pkg::CH_NL),         // lone ';' ends on this newline
            plain_row(1'b0, sxl_pkg::CH_SEMI),
            plain_row(1'b0, sxl_pkg::CH_STAR),
            plain_row(1'b0, sxl_pkg::CH_SEMI),       // ";*;" stays open
            plain_row(1'b0, sxl_pkg::CH_STAR),
            plain_row(1'b0, sxl_pkg::CH_SEMI),
            plain_row(1'b0, sxl_pkg::CH_QUOTE),
            plain_row(1'b0, sxl_pkg::CH_NUL),        // plain content inside a string
            plain_row(1'b0, sxl_pkg::CH_QUOTE),
            plain_row(1'b0, 8'h71),
            plain_row(1'b1, 8'h00),                  // pending word plus unmatched right
            fixed_row(1'b0, sxl_pkg::CH_LPAREN, sxl_pkg::KIND_LEFT, 16'd1, 16'd1, 32'd0,
                      16'd1, sxl_pkg::ERR_NONE),
            plain_row(1'b0, sxl_pkg::CH_SEMI),
            plain_row(1'b0, sxl_pkg::CH_TAB),
            fixed_row(1'b1, 8'h00, sxl_pkg::KIND_ERROR, 16'd1, 16'd1, 32'd3, 16'd0,
                      sxl_pkg::ERR_UNMATCHED_LEFT),
            plain_row(1'b0, sxl_pkg::CH_QUOTE),
            fixed_row(1'b1, 8'h00, sxl_pkg::KIND_ERROR, 16'd1, 16'd1, 32'd0, 16'd0,
                      sxl_pkg::ERR_OPEN_STRING),
            plain_row(1'b0, 8'h62),
            fixed_row(1'b0, sxl_pkg::CH_NUL, sxl_pkg::KIND_ERROR, 16'd1, 16'd2, 32'd1,
                      16'd0, sxl_pkg::ERR_NULL_BYTE),
            plain_row(1'b1, 8'h00)
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_gap_pct   = 32;
        recv_stall_pct = 87;
        load_file(16'h0000);
        foreach (script_rows[i])
            send_beat(script_rows[i].action, script_rows[i].ch, script_rows[i].has_want,
                      script_rows[i].want);
        random_phase(500);

        load_file(16'($urandom_range(65535)));
        send_gap_pct   = 87;
        recv_stall_pct = 32;
        random_phase(500);

        load_file(16'hFFFF);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        random_phase(500);

        settle();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("[sexpr_script_lexer] OK");
        else
            $display("[sexpr_script_lexer] ERROR");
        $finish;
    end

endmodule

[sexpr_script_lexer.f]
rtl/sxl_pkg.sv
rtl/sxl_core.sv
rtl/sxl_outq.sv
rtl/sexpr_script_lexer.sv
rtl/sxl_checker.sv
test/tb_sexpr_script_lexer.sv
